// File: rtl/core/assert_macros.svh
// concurrent assertion helpers, clocked on clk with active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mscd_pkg.sv
package mscd_pkg;

    localparam int CS_DEPTH = 512;
    localparam int CS_AW    = 9;

    typedef enum logic [1:0] {
        REQ_STEP   = 2'd0,
        REQ_WR_BYTE = 2'd1,
        REQ_RD_BYTE = 2'd2,
        REQ_WR_CS   = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MEM  = 3'b100
    } state_t;

    // microword layout, msb first
    typedef struct packed {
        logic [8:0] next_addr;
        logic [2:0] jump;
        logic [1:0] shift;
        logic [5:0] alu_op;
        logic [8:0] cmask;
        logic [2:0] memop;
        logic [3:0] bsel;
    } mir_t;

    typedef struct packed {
        logic [31:0] mar;
        logic [31:0] mdr;
        logic [31:0] pc;
        logic [7:0]  mbr;
        logic [31:0] sp;
        logic [31:0] lv;
        logic [31:0] cpp;
        logic [31:0] tos;
        logic [31:0] opc;
        logic [31:0] h;
    } regfile_t;

    typedef struct packed {
        logic       rd_en;
        logic [3:0] wr_be;
    } mem_ctrl_t;

    localparam logic [3:0] B_MDR  = 4'd0;
    localparam logic [3:0] B_PC   = 4'd1;
    localparam logic [3:0] B_MBR  = 4'd2;
    localparam logic [3:0] B_MBRU = 4'd3;
    localparam logic [3:0] B_SP   = 4'd4;
    localparam logic [3:0] B_LV   = 4'd5;
    localparam logic [3:0] B_CPP  = 4'd6;
    localparam logic [3:0] B_TOS  = 4'd7;
    localparam logic [3:0] B_OPC  = 4'd8;

    localparam logic [5:0] ALU_H_AND_B  = 6'd12;
    localparam logic [5:0] ALU_ONE      = 6'd17;
    localparam logic [5:0] ALU_ONES     = 6'd18;
    localparam logic [5:0] ALU_B        = 6'd20;
    localparam logic [5:0] ALU_H        = 6'd24;
    localparam logic [5:0] ALU_NOT_H    = 6'd26;
    localparam logic [5:0] ALU_H_OR_B   = 6'd28;
    localparam logic [5:0] ALU_NOT_B    = 6'd44;
    localparam logic [5:0] ALU_B_INC    = 6'd53;
    localparam logic [5:0] ALU_B_DEC    = 6'd54;
    localparam logic [5:0] ALU_H_INC    = 6'd57;
    localparam logic [5:0] ALU_NEG_H    = 6'd59;
    localparam logic [5:0] ALU_H_ADD_B  = 6'd60;
    localparam logic [5:0] ALU_H_ADD_B1 = 6'd61;
    localparam logic [5:0] ALU_B_SUB_H  = 6'd63;

    localparam logic [1:0] SH_LEFT8  = 2'd1;
    localparam logic [1:0] SH_RIGHT1 = 2'd2;

    localparam int CM_MAR = 0;
    localparam int CM_MDR = 1;
    localparam int CM_PC  = 2;
    localparam int CM_SP  = 3;
    localparam int CM_LV  = 4;
    localparam int CM_CPP = 5;
    localparam int CM_TOS = 6;
    localparam int CM_OPC = 7;
    localparam int CM_H   = 8;

    localparam int MO_FETCH = 0;
    localparam int MO_READ  = 1;
    localparam int MO_WRITE = 2;

    localparam int JMP_Z   = 0;
    localparam int JMP_NZ  = 1;
    localparam int JMP_MBR = 2;

endpackage

// File: rtl/core/mscd_req_if.sv
interface mscd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [35:0] data;

    modport source (output valid, req_type, addr, data, input ready);
    modport sink (input valid, req_type, addr, data, output ready);
endinterface

// File: rtl/core/mscd_rsp_if.sv
interface mscd_rsp_if;
    logic        valid;
    logic        ready;
    logic [8:0]  next_micro_addr;
    logic [31:0] c_bus_value;
    logic        flag_nonzero;
    logic        flag_zero;
    logic [7:0]  read_value;
    logic [31:0] top_of_stack;

    modport source (output valid, next_micro_addr, c_bus_value, flag_nonzero, flag_zero,
                    read_value, top_of_stack, input ready);
    modport sink (input valid, next_micro_addr, c_bus_value, flag_nonzero, flag_zero,
                  read_value, top_of_stack, output ready);
endinterface

// File: rtl/core/microcoded_stack_cpu_datapath.sv
// control store read at request accept, then register/alu execute with memory read,
// then memory return, write-back, next-address or and response register load;
// the next request is accepted in the memory cycle of the one before; a waiting
// response stalls that memory cycle
// reset clears the register file, flags, last c value and micro pc; control store and main memory
// are not cleared and hold undefined data until written
`include "assert_macros.svh"

module microcoded_stack_cpu_datapath #(
    parameter int MEM_BYTES = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    mscd_req_if.sink   req,
    mscd_rsp_if.source rsp
);
    import mscd_pkg::*;

    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int WAW       = $clog2(MEM_WORDS);
    localparam int BAW       = WAW + 2;

    state_t            state_reg, state_next;
    logic              accept, out_free, mem_done, is_step;
    req_kind_t         kind_reg;
    logic [15:0]       addr_reg;
    logic [35:0]       data_reg;
    mir_t              mir_reg;
    logic [35:0]       cs_mem [CS_DEPTH];
    regfile_t          regs_reg, regs_next;
    logic [CS_AW-1:0]  upc_reg, upc_next, upc_fwd, next_upc;
    logic              flag_nz_reg, flag_z_reg;
    logic [31:0]       last_c_reg;
    logic [31:0]       alu_out, c_val;
    logic              alu_nz;
    mem_ctrl_t         mem_ctrl;
    logic [WAW-1:0]    rd_a_addr, rd_b_addr, wr_addr;
    logic [31:0]       wr_data, rd_a_data, rd_b_data;
    logic [BAW-1:0]    byte_addr;
    logic [1:0]        lane_sel;
    logic [7:0]        rd_byte, mbr_new;
    logic [31:0]       mdr_new;
    logic              out_valid_reg;
    logic [8:0]        out_upc_reg;
    logic [31:0]       out_c_reg, out_tos_reg;
    logic              out_nz_reg, out_z_reg;
    logic [7:0]        out_rd_reg;

    assign is_step   = (kind_reg == REQ_STEP);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign mem_done  = (state_reg == S_MEM) && out_free;
    assign req.ready = (state_reg == S_IDLE) || mem_done;
    assign accept    = req.valid && req.ready;
    assign byte_addr = BAW'(addr_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_MEM;
            S_MEM:   state_next = out_free ? (accept ? S_EXEC : S_IDLE) : S_MEM;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= REQ_STEP;
        end
        else if (accept)
        begin
            kind_reg <= req_kind_t'(req.req_type);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= req.addr;
            data_reg <= req.data;
        end
    end

    // control store
    assign upc_fwd = ((state_reg == S_MEM) && is_step) ? next_upc : upc_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && kind_reg == REQ_WR_CS)
        begin
            cs_mem[addr_reg[CS_AW-1:0]] <= data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mir_reg <= mir_t'(cs_mem[upc_fwd]);
        end
    end

    // execute
    mscd_alu u_alu (
        .regs   (regs_reg),
        .bsel   (mir_reg.bsel),
        .op     (mir_reg.alu_op),
        .prev   (last_c_reg),
        .result (alu_out)
    );

    assign alu_nz = |alu_out;

    always_comb
    begin
        case (mir_reg.shift)
            SH_LEFT8:  c_val = alu_out << 8;
            SH_RIGHT1: c_val = alu_out >> 1;
            default:   c_val = alu_out;
        endcase
    end

    // memory data return
    assign lane_sel = is_step ? regs_reg.pc[1:0] : addr_reg[1:0];
    assign rd_byte  = rd_a_data[8*lane_sel +: 8];
    assign mbr_new  = mir_reg.memop[MO_FETCH] ? rd_byte : regs_reg.mbr;
    assign mdr_new  = mir_reg.memop[MO_READ] ? rd_b_data : regs_reg.mdr;

    always_comb
    begin
        next_upc = mir_reg.next_addr;
        next_upc[8] = next_upc[8] | (mir_reg.jump[JMP_Z] & flag_z_reg)
                    | (mir_reg.jump[JMP_NZ] & flag_nz_reg);
        if (mir_reg.jump[JMP_MBR])
        begin
            next_upc = next_upc | {1'b0, mbr_new};
        end
    end

    assign upc_next = (mem_done && is_step) ? next_upc : upc_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (state_reg == S_EXEC && is_step)
        begin
            if (mir_reg.cmask[CM_MAR]) regs_next.mar = c_val;
            if (mir_reg.cmask[CM_MDR]) regs_next.mdr = c_val;
            if (mir_reg.cmask[CM_PC])  regs_next.pc  = c_val;
            if (mir_reg.cmask[CM_SP])  regs_next.sp  = c_val;
            if (mir_reg.cmask[CM_LV])  regs_next.lv  = c_val;
            if (mir_reg.cmask[CM_CPP]) regs_next.cpp = c_val;
            if (mir_reg.cmask[CM_TOS]) regs_next.tos = c_val;
            if (mir_reg.cmask[CM_OPC]) regs_next.opc = c_val;
            if (mir_reg.cmask[CM_H])   regs_next.h   = c_val;
        end
        if (mem_done && is_step)
        begin
            regs_next.mbr = mbr_new;
            regs_next.mdr = mdr_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg    <= '0;
            upc_reg     <= '0;
            flag_nz_reg <= 1'b0;
            flag_z_reg  <= 1'b0;
            last_c_reg  <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
            upc_reg  <= upc_next;
            if (state_reg == S_EXEC && is_step)
            begin
                flag_nz_reg <= alu_nz;
                flag_z_reg  <= !alu_nz;
                last_c_reg  <= c_val;
            end
        end
    end

    // main memory access
    always_comb
    begin
        mem_ctrl.rd_en = (state_reg == S_EXEC);
        rd_a_addr      = is_step ? regs_next.pc[BAW-1:2] : byte_addr[BAW-1:2];
        rd_b_addr      = regs_next.mar[WAW-1:0];
        mem_ctrl.wr_be = 4'd0;
        wr_addr        = byte_addr[BAW-1:2];
        wr_data        = {4{data_reg[7:0]}};
        if (state_reg == S_EXEC && kind_reg == REQ_WR_BYTE)
        begin
            mem_ctrl.wr_be = 4'b0001 << byte_addr[1:0];
        end
        else if (mem_done && is_step && mir_reg.memop[MO_WRITE])
        begin
            mem_ctrl.wr_be = 4'b1111;
            wr_addr        = regs_reg.mar[WAW-1:0];
            wr_data        = mdr_new;
        end
    end

    mscd_mem #(
        .WORDS (MEM_WORDS),
        .AW    (WAW)
    ) u_mem (
        .clk       (clk),
        .ctrl      (mem_ctrl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mem_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_done)
        begin
            out_upc_reg <= upc_next;
            out_c_reg   <= last_c_reg;
            out_nz_reg  <= flag_nz_reg;
            out_z_reg   <= flag_z_reg;
            out_rd_reg  <= (kind_reg == REQ_RD_BYTE) ? rd_byte : 8'd0;
            out_tos_reg <= regs_reg.tos;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.next_micro_addr = out_upc_reg;
    assign rsp.c_bus_value     = out_c_reg;
    assign rsp.flag_nonzero    = out_nz_reg;
    assign rsp.flag_zero       = out_z_reg;
    assign rsp.read_value      = out_rd_reg;
    assign rsp.top_of_stack    = out_tos_reg;

    `ASSERT_IMPL(a_accept_free, req.valid && req.ready,
                 state_reg == S_IDLE || state_reg == S_MEM, "request accepted while busy")
    `ASSERT_NEXT(a_accept_exec, req.valid && req.ready, state_reg == S_EXEC,
                 "accepted request did not execute")
    `ASSERT_IMPL(a_flags_excl, state_reg == S_MEM && kind_reg == REQ_STEP,
                 flag_nz_reg != flag_z_reg, "flags not exclusive after step")
    `ASSERT_IMPL(a_out_from_mem, $rose(out_valid_reg), $past(state_reg) == S_MEM,
                 "response without memory turn")
    `ASSERT_IMPL(a_write_window, mem_ctrl.wr_be != 4'd0,
                 state_reg == S_EXEC || state_reg == S_MEM, "memory write while idle")
endmodule

// File: rtl/core/mscd_alu.sv
module mscd_alu (
    input  mscd_pkg::regfile_t regs,
    input  logic [3:0]         bsel,
    input  logic [5:0]         op,
    input  logic [31:0]        prev,
    output logic [31:0]        result
);
    import mscd_pkg::*;

    logic [31:0] b_val;
    logic [31:0] h_val;

    assign h_val = regs.h;

    always_comb
    begin
        case (bsel)
            B_MDR:   b_val = regs.mdr;
            B_PC:    b_val = regs.pc;
            B_MBR:   b_val = {{24{regs.mbr[7]}}, regs.mbr};
            B_MBRU:  b_val = {24'd0, regs.mbr};
            B_SP:    b_val = regs.sp;
            B_LV:    b_val = regs.lv;
            B_CPP:   b_val = regs.cpp;
            B_TOS:   b_val = regs.tos;
            B_OPC:   b_val = regs.opc;
            default: b_val = 32'hFFFF_FFFF;
        endcase
    end

    always_comb
    begin
        case (op)
            ALU_H_AND_B:  result = h_val & b_val;
            ALU_ONE:      result = 32'd1;
            ALU_ONES:     result = 32'hFFFF_FFFF;
            ALU_B:        result = b_val;
            ALU_H:        result = h_val;
            ALU_NOT_H:    result = ~h_val;
            ALU_H_OR_B:   result = h_val | b_val;
            ALU_NOT_B:    result = ~b_val;
            ALU_B_INC:    result = b_val + 32'd1;
            ALU_B_DEC:    result = b_val - 32'd1;
            ALU_H_INC:    result = h_val + 32'd1;
            ALU_NEG_H:    result = 32'd0 - h_val;
            ALU_H_ADD_B:  result = h_val + b_val;
            ALU_H_ADD_B1: result = h_val + b_val + 32'd1;
            ALU_B_SUB_H:  result = b_val - h_val;
            // unlisted op keeps the previous c value
            default:      result = prev;
        endcase
    end
endmodule

// File: rtl/core/mscd_mem.sv
module mscd_mem #(
    parameter int WORDS = 16384,
    parameter int AW    = 14
) (
    input  logic                clk,
    input  mscd_pkg::mem_ctrl_t ctrl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [31:0]         wr_data,
    input  logic [AW-1:0]       rd_a_addr,
    input  logic [AW-1:0]       rd_b_addr,
    output logic [31:0]         rd_a_data,
    output logic [31:0]         rd_b_data
);
    import mscd_pkg::*;

    // four byte lanes, little-endian word
    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (ctrl.wr_be[i])
            begin
                mem[wr_addr][8*i +: 8] <= wr_data[8*i +: 8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_a_data <= mem[rd_a_addr];
            rd_b_data <= mem[rd_b_addr];
        end
    end
endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import mscd_pkg::*;

    localparam int MEM_SIZE     = 65536;
    localparam int DIRECT_WORDS = 20;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [8:0]  upc;
        logic [31:0] cbus;
        logic        nz;
        logic        z;
        logic [7:0]  rd;
        logic [31:0] tos;
    } dp_rsp_t;

    localparam logic [5:0] ALU_CODES [15] = '{
        ALU_H_AND_B, ALU_ONE, ALU_ONES, ALU_B, ALU_H, ALU_NOT_H, ALU_H_OR_B, ALU_NOT_B,
        ALU_B_INC, ALU_B_DEC, ALU_H_INC, ALU_NEG_H, ALU_H_ADD_B, ALU_H_ADD_B1, ALU_B_SUB_H
    };

    logic clk;
    logic rst_n;

    mscd_req_if req_if();
    mscd_rsp_if rsp_if();

    microcoded_stack_cpu_datapath #(
        .MEM_BYTES(MEM_SIZE)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if)
    );

    // datapath image
    logic [31:0] m_mar, m_mdr, m_pc, m_sp, m_lv, m_cpp, m_tos, m_opc, m_h;
    logic [7:0]  m_mbr;
    logic [8:0]  m_upc;
    logic        m_flag_nz, m_flag_z;
    logic [31:0] m_last_c;
    logic [35:0] cs_img [CS_DEPTH];
    logic [7:0]  mem_img [MEM_SIZE];
    bit          cs_wr [CS_DEPTH];
    bit          mem_wr [MEM_SIZE];

    dp_rsp_t pending_rsp [$];

    bit no_idle = 1'b0;
    int mismatches = 0;
    int rsp_checked = 0;
    int steps_sent = 0;
    int reqs_sent = 0;
    int stall_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] model_alu(input mir_t mw);
        logic [31:0] bval;
        logic [31:0] alu;
        case (mw.bsel)
            B_MDR:   bval = m_mdr;
            B_PC:    bval = m_pc;
            B_MBR:   bval = {{24{m_mbr[7]}}, m_mbr};
            B_MBRU:  bval = {24'h0, m_mbr};
            B_SP:    bval = m_sp;
            B_LV:    bval = m_lv;
            B_CPP:   bval = m_cpp;
            B_TOS:   bval = m_tos;
            B_OPC:   bval = m_opc;
            default: bval = 32'hFFFF_FFFF;
        endcase
        case (mw.alu_op)
            ALU_H_AND_B:  alu = m_h & bval;
            ALU_ONE:      alu = 32'd1;
            ALU_ONES:     alu = 32'hFFFF_FFFF;
            ALU_B:        alu = bval;
            ALU_H:        alu = m_h;
            ALU_NOT_H:    alu = ~m_h;
            ALU_H_OR_B:   alu = m_h | bval;
            ALU_NOT_B:    alu = ~bval;
            ALU_B_INC:    alu = bval + 32'd1;
            ALU_B_DEC:    alu = bval - 32'd1;
            ALU_H_INC:    alu = m_h + 32'd1;
            ALU_NEG_H:    alu = 32'd0 - m_h;
            ALU_H_ADD_B:  alu = m_h + bval;
            ALU_H_ADD_B1: alu = m_h + bval + 32'd1;
            ALU_B_SUB_H:  alu = bval - m_h;
            default:      alu = m_last_c;
        endcase
        return alu;
    endfunction

    task automatic apply_to_datapath(input req_kind_t kind, input logic [15:0] a,
                                     input logic [35:0] d);
        dp_rsp_t r;
        mir_t mw;
        logic [31:0] alu;
        logic [31:0] c;
        logic nz;
        logic [8:0] nxt;
        logic [15:0] wbase;
        r.rd = 8'h00;
        case (kind)
            REQ_STEP:
            begin
                mw = cs_img[m_upc];
                alu = model_alu(mw);
                nz = (alu != 32'd0);
                case (mw.shift)
                    SH_LEFT8:  c = alu << 8;
                    SH_RIGHT1: c = alu >> 1;
                    default:   c = alu;
                endcase
                m_last_c = c;
                m_flag_nz = nz;
                m_flag_z = ~nz;
                if (mw.cmask[CM_MAR]) m_mar = c;
                if (mw.cmask[CM_MDR]) m_mdr = c;
                if (mw.cmask[CM_PC])  m_pc  = c;
                if (mw.cmask[CM_SP])  m_sp  = c;
                if (mw.cmask[CM_LV])  m_lv  = c;
                if (mw.cmask[CM_CPP]) m_cpp = c;
                if (mw.cmask[CM_TOS]) m_tos = c;
                if (mw.cmask[CM_OPC]) m_opc = c;
                if (mw.cmask[CM_H])   m_h   = c;
                if (mw.memop[MO_FETCH])
                    m_mbr = mem_img[m_pc[15:0]];
                wbase = {m_mar[13:0], 2'b00};
                if (mw.memop[MO_READ])
                    m_mdr = {mem_img[wbase + 3], mem_img[wbase + 2],
                             mem_img[wbase + 1], mem_img[wbase]};
                if (mw.memop[MO_WRITE])
                    for (int i = 0; i < 4; i++)
                    begin
                        mem_img[wbase + i] = m_mdr[8 * i +: 8];
                        mem_wr[wbase + i] = 1'b1;
                    end
                nxt = mw.next_addr;
                if (mw.jump[JMP_Z] && !nz)
                    nxt[8] = 1'b1;
                if (mw.jump[JMP_NZ] && nz)
                    nxt[8] = 1'b1;
                if (mw.jump[JMP_MBR])
                    nxt = nxt | {1'b0, m_mbr};
                m_upc = nxt;
                steps_sent++;
            end
            REQ_WR_BYTE:
            begin
                mem_img[a] = d[7:0];
                mem_wr[a] = 1'b1;
            end
            REQ_RD_BYTE: r.rd = mem_img[a];
            default:
            begin
                cs_img[a[CS_AW-1:0]] = d;
                cs_wr[a[CS_AW-1:0]] = 1'b1;
            end
        endcase
        r.upc  = m_upc;
        r.cbus = m_last_c;
        r.nz   = m_flag_nz;
        r.z    = m_flag_z;
        r.tos  = m_tos;
        pending_rsp.push_back(r);
        reqs_sent++;
    endtask

    task automatic send_request(input req_kind_t kind, input logic [15:0] a,
                                input logic [35:0] d);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 33)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid    = 1'b1;
        req_if.req_type = kind;
        req_if.addr     = a;
        req_if.data     = d;
        do
            @(posedge clk);
        while (!req_if.ready);
        apply_to_datapath(kind, a, d);
    endtask

    function automatic logic [35:0] random_microword();
        logic [63:0] raw;
        mir_t mw;
        raw = {$urandom, $urandom};
        mw = raw[35:0];
        if ($urandom_range(99) < 85)
            mw.alu_op = ALU_CODES[$urandom_range(14)];
        return mw;
    endfunction

    function automatic logic [35:0] directed_microword(input int k);
        mir_t mw;
        mw.bsel  = k[3:0];
        mw.memop = k[2:0];
        mw.shift = k[1:0];
        if (k == 0)
            mw.alu_op = ALU_ONES;
        else if (k < 16)
            mw.alu_op = ALU_CODES[k - 1];
        else if (k == 16)
            mw.alu_op = 6'd5;
        else
            mw.alu_op = ALU_CODES[$urandom_range(14)];
        if (k == 0)
            mw.cmask = 9'h1FF;
        else if (k == 7)
            mw.cmask = 9'h000;
        else
            mw.cmask = 9'($urandom);
        mw.jump = (k == DIRECT_WORDS - 1) ? 3'b111 : 3'b000;
        mw.next_addr = 9'(k + 1);
        return mw;
    endfunction

    // write the microword and the bytes the next step reads if they are still unwritten
    task automatic prepare_step();
        mir_t mw;
        logic [31:0] alu;
        logic [31:0] c;
        logic [31:0] pc_v;
        logic [31:0] mar_v;
        logic [15:0] wbase;
        if (!cs_wr[m_upc])
            send_request(REQ_WR_CS, {7'($urandom), m_upc}, random_microword());
        mw = cs_img[m_upc];
        alu = model_alu(mw);
        case (mw.shift)
            SH_LEFT8:  c = alu << 8;
            SH_RIGHT1: c = alu >> 1;
            default:   c = alu;
        endcase
        pc_v = mw.cmask[CM_PC] ? c : m_pc;
        mar_v = mw.cmask[CM_MAR] ? c : m_mar;
        if (mw.memop[MO_FETCH] && !mem_wr[pc_v[15:0]])
            send_request(REQ_WR_BYTE, pc_v[15:0], {$urandom, 4'($urandom)});
        wbase = {mar_v[13:0], 2'b00};
        if (mw.memop[MO_READ])
            for (int i = 0; i < 4; i++)
                if (!mem_wr[16'(wbase + i)])
                    send_request(REQ_WR_BYTE, 16'(wbase + i), {$urandom, 4'($urandom)});
    endtask

    task automatic send_item(input req_kind_t kind, input logic [15:0] a,
                             input logic [35:0] d);
        if (kind == REQ_STEP)
            prepare_step();
        else if (kind == REQ_RD_BYTE && !mem_wr[a])
            send_request(REQ_WR_BYTE, a, {$urandom, 4'($urandom)});
        send_request(kind, a, d);
    endtask

    task automatic send_random_request();
        int pick;
        logic [63:0] raw;
        pick = $urandom_range(99);
        raw = {$urandom, $urandom};
        if (pick < 70)
            send_item(REQ_STEP, raw[15:0], raw[51:16]);
        else if (pick < 80)
            send_item(REQ_WR_BYTE, raw[15:0], raw[51:16]);
        else if (pick < 90)
            send_item(REQ_RD_BYTE, raw[15:0], raw[51:16]);
        else
            send_item(REQ_WR_CS, raw[15:0], random_microword());
    endtask

    // directed microcode at the bottom of the control store, the rest is written on first use
    task automatic load_stores();
        logic [6:0] upper;
        for (int i = 0; i < DIRECT_WORDS; i++)
        begin
            upper = 7'($urandom);
            send_request(REQ_WR_CS, {upper, 9'(i)}, directed_microword(i));
        end
    endtask

    task automatic test_directed_cases();
        for (int k = 0; k < DIRECT_WORDS; k++)
            send_item(REQ_STEP, 16'h0000, 36'h0);
        send_item(REQ_WR_BYTE, 16'hFFFF, 36'hF_FFFF_FFFF);
        send_item(REQ_RD_BYTE, 16'hFFFF, 36'h0);
        send_item(REQ_RD_BYTE, 16'h0000, 36'hF_FFFF_FFFF);
        send_item(REQ_WR_CS, 16'hFFFF, 36'hF_FFFF_FFFF);
    endtask

    task automatic test_random_program(input int upto);
        while (reqs_sent < upto)
            send_random_request();
    endtask

    task automatic test_full_rate(input int upto);
        no_idle = 1'b1;
        while (reqs_sent < upto)
            send_random_request();
        no_idle = 1'b0;
    endtask

    task automatic test_drain_then_resume(input int upto);
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        while (reqs_sent < upto)
            send_random_request();
    endtask

    task automatic check_field(input string name, input logic [35:0] exp_v,
                               input logic [35:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v,
                     got_v);
        end
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready = no_idle || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        dp_rsp_t e;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with nothing outstanding, expected none, actual %h",
                         $time, rsp_if.c_bus_value);
            end
            else
            begin
                e = pending_rsp.pop_front();
                check_field("next_micro_addr", e.upc, rsp_if.next_micro_addr);
                check_field("c_bus_value", e.cbus, rsp_if.c_bus_value);
                check_field("flag_nonzero", e.nz, rsp_if.flag_nonzero);
                check_field("flag_zero", e.z, rsp_if.flag_zero);
                check_field("read_value", e.rd, rsp_if.read_value);
                check_field("top_of_stack", e.tos, rsp_if.top_of_stack);
                rsp_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_STEP;
        req_if.addr = 16'h0000;
        req_if.data = 36'h0;
        m_mar = '0; m_mdr = '0; m_pc = '0; m_sp = '0; m_lv = '0;
        m_cpp = '0; m_tos = '0; m_opc = '0; m_h = '0; m_mbr = '0;
        m_upc = '0; m_flag_nz = 1'b0; m_flag_z = 1'b0; m_last_c = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_stores();
        test_directed_cases();
        test_random_program(600);
        test_full_rate(900);
        test_drain_then_resume(1200);

        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("summary: %0d requests checked, %0d of them microsteps over random microcode",
                 rsp_checked, steps_sent);
        $display("summary: memory and microwords filled on first use, %0d field mismatches",
                 mismatches);
        if (mismatches == 0 && rsp_checked == reqs_sent)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mscd_pkg.sv
rtl/core/mscd_req_if.sv
rtl/core/mscd_rsp_if.sv
rtl/core/mscd_alu.sv
rtl/core/mscd_mem.sv
rtl/core/microcoded_stack_cpu_datapath.sv
test/tb_top.sv
